// ===== src/gtas_pkg.sv =====
`timescale 1ns / 1ps

package gtas_pkg;

    // Default geometry
    localparam int POSITION_WIDTH_DEF = 14;
    localparam int GRID_SIDE_DEF      = 16;

    // Field widths
    localparam int CELL_W  = 8;
    localparam int COL_W   = 8;
    localparam int ROW_W   = 4;
    localparam int GAIN_W  = 8;
    localparam int ORIG_W  = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN  = 2'd2;

    // Register reset values
    localparam logic [GAIN_W-1:0] STEP_GAIN_RST = 8'd130;
    localparam logic [ORIG_W-1:0] X_ORIGIN_RST  = 11'd1140;
    localparam logic [ORIG_W-1:0] Y_ORIGIN_RST  = 11'd280;

    typedef enum logic [1:0] {
        OP_MOVE    = 2'd0,
        OP_DISCARD = 2'd1,
        OP_TICK    = 2'd2,
        OP_HOME    = 2'd3
    } op_t;

    typedef struct packed {
        op_t              operation;
        logic [CELL_W-1:0] grid_cell;
        logic             x_switch_open;
        logic             y_switch_open;
    } cmd_t;

    typedef struct packed {
        logic x_step;
        logic y_step;
        logic x_direction;
        logic y_direction;
        logic x_reached;
        logic y_reached;
        logic homing_busy;
        logic motion_enabled;
    } res_t;

    // Control carried from the front stage to the motion core
    typedef struct packed {
        op_t  op;
        logic x_switch_open;
        logic y_switch_open;
    } stage_ctl_t;

endpackage

// ===== src/grid_target_two_axis_stepper.sv =====
// A command transfer passes the front register and then the result register before its result shows.
// Throughput: one command per cycle while res_ready holds; the motion core retires one item per cycle.
// The front register holds the computed grid targets, the core updates state and
// loads the result register, so the two sides stall independently.
// Reset (rst_n, async, active low) clears all motion state and restores the registers.
`timescale 1ns / 1ps

module grid_target_two_axis_stepper #(
    parameter int POSITION_WIDTH = gtas_pkg::POSITION_WIDTH_DEF,
    parameter int GRID_SIDE      = gtas_pkg::GRID_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration writes: taken on any cycle with cfg_write high
    input  logic                            cfg_write,
    input  logic [gtas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtas_pkg::CFG_DATA_W-1:0] cfg_data,
    // Command channel
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  gtas_pkg::cmd_t                  cmd,
    // Result channel
    output logic                            res_valid,
    input  logic                            res_ready,
    output gtas_pkg::res_t                  res
);

    logic                      stage_valid;
    logic                      stage_ready;
    gtas_pkg::stage_ctl_t      stage_ctl;
    logic [POSITION_WIDTH-1:0] stage_x_target;
    logic [POSITION_WIDTH-1:0] stage_y_target;

    // Front: hold the register file, split the cell into column and row,
    // and compute the grid targets (origin -/+ gain * index) at transfer.
    gtas_front #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .GRID_SIDE      (GRID_SIDE)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd),
        .stage_valid    (stage_valid),
        .stage_ready    (stage_ready),
        .stage_ctl      (stage_ctl),
        .stage_x_target (stage_x_target),
        .stage_y_target (stage_y_target)
    );

    // Core: start moves (travel and direction from the previous target),
    // advance step counters on ticks, run homing, and register the result.
    gtas_core #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage_valid    (stage_valid),
        .stage_ready    (stage_ready),
        .stage_ctl      (stage_ctl),
        .stage_x_target (stage_x_target),
        .stage_y_target (stage_y_target),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

endmodule

// ===== src/gtas_front.sv =====
`timescale 1ns / 1ps

module gtas_front #(
    parameter int POSITION_WIDTH = gtas_pkg::POSITION_WIDTH_DEF,
    parameter int GRID_SIDE      = gtas_pkg::GRID_SIDE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [gtas_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gtas_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  gtas_pkg::cmd_t                    cmd,
    output logic                              stage_valid,
    input  logic                              stage_ready,
    output gtas_pkg::stage_ctl_t              stage_ctl,
    output logic [POSITION_WIDTH-1:0]         stage_x_target,
    output logic [POSITION_WIDTH-1:0]         stage_y_target
);

    localparam int CELLS = 1 << gtas_pkg::CELL_W;

    logic [gtas_pkg::GAIN_W-1:0] gain_reg;
    logic [gtas_pkg::ORIG_W-1:0] x_origin_reg;
    logic [gtas_pkg::ORIG_W-1:0] y_origin_reg;

    logic [gtas_pkg::COL_W-1:0] col_lut [CELLS];
    logic [gtas_pkg::ROW_W-1:0] row_lut [CELLS];

    logic [gtas_pkg::COL_W-1:0] col;
    logic [gtas_pkg::ROW_W-1:0] row;
    logic [15:0]                x_offset;
    logic [15:0]                y_offset;
    logic [POSITION_WIDTH-1:0]  x_target;
    logic [POSITION_WIDTH-1:0]  y_target;

    logic                       take;
    logic                       stage_valid_reg, stage_valid_next;
    gtas_pkg::stage_ctl_t       ctl_reg;
    logic [POSITION_WIDTH-1:0]  x_target_reg;
    logic [POSITION_WIDTH-1:0]  y_target_reg;

    // Cell to column/row split, worked out at elaboration
    for (genvar i = 0; i < CELLS; i++) begin : g_lut
        assign col_lut[i] = gtas_pkg::COL_W'(i / GRID_SIDE);
        assign row_lut[i] = gtas_pkg::ROW_W'(i % GRID_SIDE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= gtas_pkg::STEP_GAIN_RST;
            x_origin_reg <= gtas_pkg::X_ORIGIN_RST;
            y_origin_reg <= gtas_pkg::Y_ORIGIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gtas_pkg::CFG_STEP_GAIN: gain_reg <= cfg_data[gtas_pkg::GAIN_W-1:0];
                gtas_pkg::CFG_X_ORIGIN:  x_origin_reg <= cfg_data;
                gtas_pkg::CFG_Y_ORIGIN:  y_origin_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Candidate targets, wrapped to the position width
    always_comb
    begin
        col      = col_lut[cmd.grid_cell];
        row      = row_lut[cmd.grid_cell];
        x_offset = 16'(gain_reg) * 16'(col);
        y_offset = 16'(gain_reg) * 16'(row);
        x_target = POSITION_WIDTH'(x_origin_reg) - x_offset[POSITION_WIDTH-1:0];
        y_target = POSITION_WIDTH'(y_origin_reg) + y_offset[POSITION_WIDTH-1:0];
    end

    assign cmd_ready        = !stage_valid_reg || stage_ready;
    assign take             = cmd_valid && cmd_ready;
    assign stage_valid_next = take || (stage_valid_reg && !stage_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctl_reg.op            <= cmd.operation;
            ctl_reg.x_switch_open <= cmd.x_switch_open;
            ctl_reg.y_switch_open <= cmd.y_switch_open;
            x_target_reg          <= x_target;
            y_target_reg          <= y_target;
        end
    end

    assign stage_valid    = stage_valid_reg;
    assign stage_ctl      = ctl_reg;
    assign stage_x_target = x_target_reg;
    assign stage_y_target = y_target_reg;

endmodule

// ===== src/gtas_core.sv =====
`timescale 1ns / 1ps

module gtas_core #(
    parameter int POSITION_WIDTH = gtas_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      stage_valid,
    output logic                      stage_ready,
    input  gtas_pkg::stage_ctl_t      stage_ctl,
    input  logic [POSITION_WIDTH-1:0] stage_x_target,
    input  logic [POSITION_WIDTH-1:0] stage_y_target,
    output logic                      res_valid,
    input  logic                      res_ready,
    output gtas_pkg::res_t            res
);

    localparam int LW = POSITION_WIDTH + 1;

    logic [POSITION_WIDTH-1:0] x_to_reg, x_to_next;
    logic [POSITION_WIDTH-1:0] y_to_reg, y_to_next;
    logic [LW-1:0]             x_travel_reg, x_travel_next;
    logic [LW-1:0]             y_travel_reg, y_travel_next;
    logic [LW-1:0]             x_done_reg, x_done_next;
    logic [LW-1:0]             y_done_reg, y_done_next;
    logic [1:0]                arrival_reg, arrival_next;
    logic [1:0]                dir_reg, dir_next;
    logic                      run_reg, run_next;
    logic                      home_reg, home_next;
    logic                      res_valid_reg, res_valid_next;
    gtas_pkg::res_t            res_reg, res_next;

    logic                      fire;
    logic                      xs, ys;
    logic [POSITION_WIDTH-1:0] new_x, new_y;
    logic [LW-1:0]             dx, dy, x_len, y_len;

    assign stage_ready = !res_valid_reg || res_ready;
    assign fire        = stage_valid && stage_ready;

    always_comb
    begin
        x_to_next     = x_to_reg;
        y_to_next     = y_to_reg;
        x_travel_next = x_travel_reg;
        y_travel_next = y_travel_reg;
        x_done_next   = x_done_reg;
        y_done_next   = y_done_reg;
        arrival_next  = arrival_reg;
        dir_next      = dir_reg;
        run_next      = run_reg;
        home_next     = home_reg;
        xs            = 1'b0;
        ys            = 1'b0;

        // Discard keeps x and heads y to zero
        new_x = (stage_ctl.op == gtas_pkg::OP_MOVE) ? stage_x_target : x_to_reg;
        new_y = (stage_ctl.op == gtas_pkg::OP_MOVE) ? stage_y_target : '0;
        dx    = {new_x[POSITION_WIDTH-1], new_x} - {x_to_reg[POSITION_WIDTH-1], x_to_reg};
        dy    = {new_y[POSITION_WIDTH-1], new_y} - {y_to_reg[POSITION_WIDTH-1], y_to_reg};
        x_len = dx[LW-1] ? (~dx + LW'(1)) : dx;
        y_len = dy[LW-1] ? (~dy + LW'(1)) : dy;

        if (fire)
        begin
            case (stage_ctl.op)
                gtas_pkg::OP_MOVE, gtas_pkg::OP_DISCARD:
                begin
                    if (!home_reg)
                    begin
                        x_to_next     = new_x;
                        y_to_next     = new_y;
                        x_travel_next = x_len;
                        y_travel_next = y_len;
                        arrival_next  = {y_len == '0, x_len == '0};
                        dir_next      = {dy[LW-1], dx[LW-1]};
                        x_done_next   = '0;
                        y_done_next   = '0;
                        run_next      = 1'b1;
                    end
                end
                gtas_pkg::OP_TICK:
                begin
                    if (home_reg)
                    begin
                        xs = !stage_ctl.x_switch_open;
                        ys = !stage_ctl.y_switch_open;
                        if (stage_ctl.x_switch_open && stage_ctl.y_switch_open)
                        begin
                            home_next    = 1'b0;
                            x_to_next    = '0;
                            y_to_next    = '0;
                            arrival_next = 2'b11;
                            run_next     = 1'b0;
                        end
                    end
                    else if (run_reg)
                    begin
                        if (x_done_reg < x_travel_reg)
                        begin
                            xs          = 1'b1;
                            x_done_next = x_done_reg + LW'(1);
                        end
                        else
                            arrival_next[0] = 1'b1;
                        if (y_done_reg < y_travel_reg)
                        begin
                            ys          = 1'b1;
                            y_done_next = y_done_reg + LW'(1);
                        end
                        else
                            arrival_next[1] = 1'b1;
                        if (arrival_next == 2'b11)
                            run_next = 1'b0;
                    end
                end
                gtas_pkg::OP_HOME:
                begin
                    home_next = 1'b1;
                    run_next  = 1'b1;
                    dir_next  = 2'b11;
                end
                default: ;
            endcase
        end

        res_next.x_step         = xs;
        res_next.y_step         = ys;
        res_next.x_direction    = dir_next[0];
        res_next.y_direction    = dir_next[1];
        res_next.x_reached      = arrival_next[0];
        res_next.y_reached      = arrival_next[1];
        res_next.homing_busy    = home_next;
        res_next.motion_enabled = run_next;

        res_valid_next = fire || (res_valid_reg && !res_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_to_reg      <= '0;
            y_to_reg      <= '0;
            x_travel_reg  <= '0;
            y_travel_reg  <= '0;
            x_done_reg    <= '0;
            y_done_reg    <= '0;
            arrival_reg   <= '0;
            dir_reg       <= '0;
            run_reg       <= 1'b0;
            home_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            x_to_reg      <= x_to_next;
            y_to_reg      <= y_to_next;
            x_travel_reg  <= x_travel_next;
            y_travel_reg  <= y_travel_next;
            x_done_reg    <= x_done_next;
            y_done_reg    <= y_done_next;
            arrival_reg   <= arrival_next;
            dir_reg       <= dir_next;
            run_reg       <= run_next;
            home_reg      <= home_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== src/gtas_checker.sv =====
`timescale 1ns / 1ps

module gtas_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input logic           res_valid,
    input logic           res_ready,
    input gtas_pkg::res_t res
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // A command transfer always has a result pending once it has passed the front and result registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> ##2 res_valid)
        else $error("no result after command transfer");

    // A step pulse only comes while motion runs
    a_step_runs: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.x_step || res.y_step) |-> res.motion_enabled)
        else $error("step without motion");

    // Homing drives both axes toward smaller positions with motion on
    a_home_dir: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.homing_busy |->
            res.motion_enabled && res.x_direction && res.y_direction)
        else $error("homing state inconsistent");

    // Outside homing an axis that steps has not arrived
    a_step_arrive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.homing_busy && (res.x_step || res.y_step) |->
            !(res.x_step && res.x_reached) && !(res.y_step && res.y_reached))
        else $error("step on arrived axis");

endmodule

bind grid_target_two_axis_stepper gtas_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
